@@ hdl/mhpq_pkg.sv @@
// Shared constants and controller/datapath interface types for the min-heap queue.
package mhpq_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = ADDR_W + 2;
	localparam int OCNT_W   = 5;
	localparam int OUT_W    = 40;

	// commands from controller to datapath
	typedef struct packed {
		logic start;      // latch value, pos <= count
		logic up_read;    // read parent of pos
		logic up_move;    // parent moves down into pos, pos <= parent
		logic place;      // write held item at pos
		logic count_inc;
		logic last_read;  // read last entry
		logic last_load;  // held item <= last entry, count--, pos <= root
		logic down_read;  // read both children of pos
		logic down_move;  // smaller child moves up into pos, pos <= child
		logic result_load;
		logic result_rej;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic pos_zero;
		logic up_less;
		logic no_left;
		logic down_sel;
		logic out_free;
	} sts_t;

endpackage

@@ hdl/mhpq_ctrl.sv @@
// Controller state machine sequencing push sift-up and pop sift-down.
module mhpq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_mode,
	output logic          in_ready,
	input  mhpq_pkg::sts_t sts,
	output mhpq_pkg::cmd_t cmd
);
	import mhpq_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		PUSH_RD,
		PUSH_CMP,
		POP_RD,
		POP_LD,
		DOWN_RD,
		DOWN_CMP,
		FINISH
	} state_t;

	localparam logic MODE_PUSH = 1'b0;

	state_t state_q, state_d;
	logic   rej_q, rej_d;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		rej_d   = rej_q;
		case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					rej_d     = 1'b0;
					if (in_mode == MODE_PUSH) begin
						if (sts.full) begin
							rej_d   = 1'b1;
							state_d = FINISH;
						end else begin
							state_d = PUSH_RD;
						end
					end else begin
						if (sts.empty) begin
							rej_d   = 1'b1;
							state_d = FINISH;
						end else begin
							state_d = POP_RD;
						end
					end
				end
			end
			PUSH_RD: begin
				if (sts.pos_zero) begin
					cmd.place     = 1'b1;
					cmd.count_inc = 1'b1;
					state_d       = FINISH;
				end else begin
					cmd.up_read = 1'b1;
					state_d     = PUSH_CMP;
				end
			end
			PUSH_CMP: begin
				if (sts.up_less) begin
					cmd.up_move = 1'b1;
					state_d     = PUSH_RD;
				end else begin
					cmd.place     = 1'b1;
					cmd.count_inc = 1'b1;
					state_d       = FINISH;
				end
			end
			POP_RD: begin
				cmd.last_read = 1'b1;
				state_d       = POP_LD;
			end
			POP_LD: begin
				cmd.last_load = 1'b1;
				state_d       = DOWN_RD;
			end
			DOWN_RD: begin
				if (sts.no_left) begin
					cmd.place = 1'b1;
					state_d   = FINISH;
				end else begin
					cmd.down_read = 1'b1;
					state_d       = DOWN_CMP;
				end
			end
			DOWN_CMP: begin
				if (sts.down_sel) begin
					cmd.down_move = 1'b1;
					state_d       = DOWN_RD;
				end else begin
					cmd.place = 1'b1;
					state_d   = FINISH;
				end
			end
			FINISH: begin
				if (sts.out_free) begin
					cmd.result_load = 1'b1;
					state_d         = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
		cmd.result_rej = rej_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			rej_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rej_q   <= rej_d;
		end
	end

endmodule

@@ hdl/mhpq_dp.sv @@
// Datapath: heap memory, cursor registers, compare logic and result register.
module mhpq_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [mhpq_pkg::DATA_W-1:0] in_value,
	input  mhpq_pkg::cmd_t                   cmd,
	output mhpq_pkg::sts_t                   sts,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mhpq_pkg::OUT_W-1:0]       out_data
);
	import mhpq_pkg::*;

	logic signed [DATA_W-1:0] mem [CAPACITY];

	logic        [CNT_W-1:0]  count_q;
	logic        [ADDR_W-1:0] pos_q;
	logic signed [DATA_W-1:0] cur_q;
	logic signed [DATA_W-1:0] root_q;
	logic signed [DATA_W-1:0] rd0_q, rd1_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_top_q;
	logic        [OCNT_W-1:0] out_cnt_q;
	logic                     out_empty_q;
	logic                     out_rej_q;

	logic        [ADDR_W-1:0] parent;
	logic        [IDX_W-1:0]  l_idx, r_idx, cnt_ext;
	logic                     l_ok, r_ok, l_lt, r_lt;
	logic signed [DATA_W-1:0] sel_val, best_val;
	logic        [ADDR_W-1:0] best_pos;
	logic                     rd_en0, rd_en1;
	logic        [ADDR_W-1:0] rd_addr0, rd_addr1;
	logic                     wr_en;
	logic signed [DATA_W-1:0] wr_data;

	assign parent  = (pos_q - 1'b1) >> 1;
	assign l_idx   = {1'b0, pos_q, 1'b1};
	assign r_idx   = l_idx + 1'b1;
	assign cnt_ext = IDX_W'(count_q);
	assign l_ok    = l_idx < cnt_ext;
	assign r_ok    = r_idx < cnt_ext;

	// left child wins a tie; only strictly smaller children move up
	always_comb begin
		l_lt     = l_ok && (rd0_q < cur_q);
		sel_val  = l_lt ? rd0_q : cur_q;
		r_lt     = r_ok && (rd1_q < sel_val);
		best_val = r_lt ? rd1_q : rd0_q;
		best_pos = r_lt ? r_idx[ADDR_W-1:0] : l_idx[ADDR_W-1:0];
	end

	always_comb begin
		sts.full     = (count_q == CNT_W'(CAPACITY));
		sts.empty    = (count_q == '0);
		sts.pos_zero = (pos_q == '0);
		sts.up_less  = (cur_q < rd0_q);
		sts.no_left  = !l_ok;
		sts.down_sel = l_lt || r_lt;
		sts.out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		rd_en0   = cmd.up_read | cmd.last_read | cmd.down_read;
		rd_en1   = cmd.down_read;
		rd_addr0 = parent;
		if (cmd.last_read) begin
			rd_addr0 = ADDR_W'(count_q - 1'b1);
		end else if (cmd.down_read) begin
			rd_addr0 = l_idx[ADDR_W-1:0];
		end
		rd_addr1 = r_idx[ADDR_W-1:0];
		wr_en    = cmd.place | cmd.up_move | cmd.down_move;
		wr_data  = best_val;
		if (cmd.place) begin
			wr_data = cur_q;
		end else if (cmd.up_move) begin
			wr_data = rd0_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pos_q] <= wr_data;
		end
		if (rd_en0) begin
			rd0_q <= mem[rd_addr0];
		end
		if (rd_en1) begin
			rd1_q <= mem[rd_addr1];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cur_q <= in_value;
			pos_q <= ADDR_W'(count_q);
		end else if (cmd.last_load) begin
			cur_q <= rd0_q;
			pos_q <= '0;
		end else if (cmd.up_move) begin
			pos_q <= parent;
		end else if (cmd.down_move) begin
			pos_q <= best_pos;
		end
		// copy of the root entry kept for the result
		if (wr_en && pos_q == '0) begin
			root_q <= wr_data;
		end
		if (cmd.result_load) begin
			out_top_q   <= (count_q != '0) ? root_q : '0;
			out_cnt_q   <= OCNT_W'(count_q);
			out_empty_q <= (count_q == '0);
			out_rej_q   <= cmd.result_rej;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.count_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.last_load) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {1'b0, out_rej_q, out_empty_q, out_cnt_q, out_top_q};

endmodule

@@ hdl/min_heap_priority_queue.sv @@
// Push sifts the item up: per level the parent is read, compared and moved down if larger.
// Pop loads the last entry as the root item and sifts it down, reading and comparing both
// children per level. A refused item goes straight to the final state. At 16 entries an
// item moves up at most four levels and down at most three. One item at a time; a result
// held by m_axis_tready stalls the block in its final state. Reset: arst_n clears the count
// and output valid; heap memory is not cleared, entries are only used after being written.
module min_heap_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	input  logic [0:0]  s_axis_tuser,  // [0] mode: 0 push, 1 pop
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // [31:0] top_value, [36:32] entry_count,
	                                   // [37] is_empty, [38] rejected, [39] zero
);
	import mhpq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mhpq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_value  ($signed(s_axis_tdata)),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
